// ----- rtl/rsa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the refcounted slot allocator.
// No dependencies.
package rsa_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned BYTE_COUNT = SLOT_COUNT / 8;
  localparam int unsigned BYTE_W     = $clog2(BYTE_COUNT);
  localparam int unsigned LINK_W     = SLOT_W + 1;
  localparam int unsigned REF_BITS   = 16;
  localparam int unsigned ID_W       = 64;
  localparam int unsigned FLAGS_W    = 32;
  localparam int unsigned CFG_W      = 10;

  localparam logic [7:0]          FULL_BYTE = 8'hff;
  localparam logic [REF_BITS-1:0] REF_MAX   = '1;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic CFG_FIRST_SLOT = 1'b0;
  localparam logic CFG_LAST_SLOT  = 1'b1;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_SHARED     = 3'd1,
    ST_DECR       = 3'd2,
    ST_FREED      = 3'd3,
    ST_NO_SPACE   = 3'd4,
    ST_TABLE_FULL = 3'd5,
    ST_NOT_FOUND  = 3'd6,
    ST_MISMATCH   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    VIEW_NONE  = 2'd0,
    VIEW_SET   = 2'd1,
    VIEW_CLEAR = 2'd2
  } view_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_OVF_RD,
    S_OVF_CHK,
    S_LINK,
    S_BCLR_RD,
    S_BCLR_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]     id_hi;
    logic [ID_W-1:0]     id_lo;
    logic [FLAGS_W-1:0]  flags;
    logic [SLOT_W-1:0]   slot;
    logic [REF_BITS-1:0] refs;
    logic [LINK_W-1:0]   link;
  } entry_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              both;
    logic              ovf;
    logic [SLOT_W-1:0] addr;
    entry_t            wdata;
  } ent_req_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [BYTE_W-1:0] addr;
    logic [7:0]        wdata;
  } bm_req_t;

endpackage

// ----- rtl/rsa_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the refcounted slot allocator: request, response, config.
// Depends on rsa_pkg.
interface rsa_req_if import rsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    object_id_high;
  logic [ID_W-1:0]    object_id_low;
  logic [FLAGS_W-1:0] request_flags;
  logic [SLOT_W-1:0]  release_slot;

  modport source (output valid, action, object_id_high, object_id_low, request_flags,
                  release_slot, input ready);
  modport sink (input valid, action, object_id_high, object_id_low, request_flags,
                release_slot, output ready);
endinterface

interface rsa_rsp_if import rsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_number;
  logic [2:0]        status;
  logic [1:0]        view_update;

  modport source (output valid, slot_number, status, view_update, input ready);
  modport sink (input valid, slot_number, status, view_update, output ready);
endinterface

interface rsa_cfg_if import rsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rsa_tables.sv -----
`timescale 1ns / 1ps
// Home table, overflow table and slot bitmap: synchronous memories with registered read.
// Depends on rsa_pkg.
module rsa_tables import rsa_pkg::*; (
  input  logic       clk_i,
  input  ent_req_t   ent_req_i,
  input  bm_req_t    bm_req_i,
  output entry_t     ent_rdata_o,
  output logic [7:0] bm_rdata_o
);

  entry_t     home_mem [SLOT_COUNT];
  entry_t     ovf_mem  [SLOT_COUNT];
  logic [7:0] bm_mem   [BYTE_COUNT];

  entry_t     home_rd_q;
  entry_t     ovf_rd_q;
  logic       rd_ovf_q;
  logic [7:0] bm_rd_q;

  always_ff @(posedge clk_i) begin
    if (ent_req_i.wr && (ent_req_i.both || !ent_req_i.ovf)) begin
      home_mem[ent_req_i.addr] <= ent_req_i.wdata;
    end
    if (ent_req_i.rd && !ent_req_i.ovf) begin
      home_rd_q <= home_mem[ent_req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_req_i.wr && (ent_req_i.both || ent_req_i.ovf)) begin
      ovf_mem[ent_req_i.addr] <= ent_req_i.wdata;
    end
    if (ent_req_i.rd && ent_req_i.ovf) begin
      ovf_rd_q <= ovf_mem[ent_req_i.addr];
    end
    if (ent_req_i.rd) begin
      rd_ovf_q <= ent_req_i.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_req_i.wr) begin
      bm_mem[bm_req_i.addr] <= bm_req_i.wdata;
    end
    if (bm_req_i.rd) begin
      bm_rd_q <= bm_mem[bm_req_i.addr];
    end
  end

  assign ent_rdata_o = rd_ovf_q ? ovf_rd_q : home_rd_q;
  assign bm_rdata_o  = bm_rd_q;

endmodule

// ----- rtl/refcounted_slot_allocator.sv -----
`timescale 1ns / 1ps
// Refcounted slot allocator: maps (object id, flags) to a shared slot with a count.
// Channels: cfg_i writes alloc_first_slot (index 0) and alloc_last_slot (index 1);
// ready is always high. req_i takes one item; rsp_o returns exactly one item for it.
// Steps from request accept to response valid:
//   zero id: no memory step; hit or release miss: a read and check per chain entry
//   visited, then a bitmap read and write to free the bit on a last release; allocate
//   miss adds a read and check per bitmap byte scanned, and reports no space when the
//   scan runs out of bytes; when the chain holds no empty entry it searches the overflow
//   table (up to 1024 entries), then links the entry or reports a full table. Every step
//   is one read of a single-port memory with registered read, then a check of the entry.
// One item is in work at a time; a finished result sits in an output register,
// so the next item is accepted while the receiver stalls. A second finished
// result waits until the output register is taken.
// Reset: after rst_ni rises, a clearing pass zeroes both tables and the bitmap;
// req_i.ready stays low during it, config writes are taken.
module refcounted_slot_allocator import rsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  rsa_cfg_if.sink  cfg_i,
  rsa_req_if.sink  req_i,
  rsa_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  logic [SLOT_W-1:0]   clr_q, clr_d;
  logic [SLOT_W-1:0]   first_q, last_q;

  logic                act_q, act_d;
  logic [ID_W-1:0]     hi_q, hi_d, lo_q, lo_d;
  logic [FLAGS_W-1:0]  fl_q, fl_d;
  logic [SLOT_W-1:0]   rslot_q, rslot_d;

  logic                cur_ovf_q, cur_ovf_d;
  logic [SLOT_W-1:0]   cur_at_q, cur_at_d;
  logic                emp_vld_q, emp_vld_d;
  logic                emp_ovf_q, emp_ovf_d;
  logic [SLOT_W-1:0]   emp_at_q, emp_at_d;
  logic [LINK_W-1:0]   emp_link_q, emp_link_d;
  logic                tail_ovf_q, tail_ovf_d;
  logic [SLOT_W-1:0]   tail_at_q, tail_at_d;
  entry_t              tail_ent_q, tail_ent_d;
  logic [BYTE_W:0]     byte_q, byte_d;
  logic [7:0]          bm_byte_q, bm_byte_d;
  logic [LINK_W-1:0]   ovf_idx_q, ovf_idx_d;

  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  status_e             res_status_q, res_status_d;
  view_e               res_view_q, res_view_d;

  logic                out_vld_q, out_vld_d;
  logic [SLOT_W-1:0]   out_slot_q;
  status_e             out_status_q;
  view_e               out_view_q;

  ent_req_t            ent_req;
  bm_req_t             bm_req;
  entry_t              ent;
  logic [7:0]          bm_rdata;

  logic                req_fire, rsp_fire, out_load;
  logic                occupied, match, link_ok, ovf_free, mismatch, last_ref;
  logic [BYTE_W:0]     first_byte, last_byte;
  logic                scan_end, byte_full;
  logic [2:0]          free_bit;
  logic [SLOT_W-1:0]   new_slot;
  logic [7:0]          set_byte;
  entry_t              hit_upd;
  entry_t              fill_ent;

  rsa_tables u_tables (
    .clk_i       (clk_i),
    .ent_req_i   (ent_req),
    .bm_req_i    (bm_req),
    .ent_rdata_o (ent),
    .bm_rdata_o  (bm_rdata)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign out_load    = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.slot_number = out_slot_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.view_update = out_view_q;

  assign occupied = |{ent.id_hi, ent.id_lo};
  assign match    = occupied && (ent.id_hi == hi_q) && (ent.id_lo == lo_q)
                    && (ent.flags == fl_q);
  assign link_ok  = (ent.link != '0) && (ent.link <= LINK_W'(SLOT_COUNT));
  assign ovf_free = !occupied && (ent.link == '0);
  assign mismatch = (ent.slot != rslot_q);
  assign last_ref = (ent.refs <= REF_BITS'(1));

  assign first_byte = {1'b0, first_q[SLOT_W-1:3]};
  assign last_byte  = {1'b0, last_q[SLOT_W-1:3]};
  assign scan_end   = (byte_q > last_byte) || (byte_q >= (BYTE_W + 1)'(BYTE_COUNT));
  assign byte_full  = (bm_rdata == FULL_BYTE);

  always_comb begin
    free_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!bm_rdata[i]) begin
        free_bit = 3'(i);
      end
    end
  end

  assign new_slot = {byte_q[BYTE_W-1:0], free_bit};
  assign set_byte = bm_rdata | (8'b1 << free_bit);

  always_comb begin
    hit_upd = ent;
    if (act_q == ACT_ALLOC) begin
      if (ent.refs != REF_MAX) begin
        hit_upd.refs = ent.refs + REF_BITS'(1);
      end
    end else if (!last_ref) begin
      hit_upd.refs = ent.refs - REF_BITS'(1);
    end else begin
      hit_upd       = '0;
      hit_upd.link  = ent.link;
    end
  end

  always_comb begin
    fill_ent       = '0;
    fill_ent.id_hi = hi_q;
    fill_ent.id_lo = lo_q;
    fill_ent.flags = fl_q;
    fill_ent.refs  = REF_BITS'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == SLOT_W'(SLOT_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          if ((req_i.object_id_high | req_i.object_id_low) == '0) state_d = S_DONE;
          else state_d = S_FIND_RD;
        end
      end
      S_FIND_RD: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        priority if (match) begin
          if (act_q == ACT_RELEASE && !mismatch && last_ref) state_d = S_BCLR_RD;
          else state_d = S_DONE;
        end else if (link_ok) begin
          state_d = S_FIND_RD;
        end else if (act_q == ACT_RELEASE) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_d = scan_end ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK: begin
        priority if (byte_full) state_d = S_SCAN_RD;
        else if (emp_vld_q) state_d = S_DONE;
        else state_d = S_OVF_RD;
      end
      S_OVF_RD: state_d = (ovf_idx_q == LINK_W'(SLOT_COUNT)) ? S_DONE : S_OVF_CHK;
      S_OVF_CHK: state_d = ovf_free ? S_LINK : S_OVF_RD;
      S_LINK: state_d = S_DONE;
      S_BCLR_RD: state_d = S_BCLR_WR;
      S_BCLR_WR: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // memory requests
  always_comb begin
    ent_req = '0;
    bm_req  = '0;
    unique case (state_q)
      S_CLEAR: begin
        ent_req.wr   = 1'b1;
        ent_req.both = 1'b1;
        ent_req.addr = clr_q;
        bm_req.wr    = 1'b1;
        bm_req.addr  = clr_q[BYTE_W-1:0];
      end
      S_FIND_RD: begin
        ent_req.rd   = 1'b1;
        ent_req.ovf  = cur_ovf_q;
        ent_req.addr = cur_at_q;
      end
      S_FIND_CHK: begin
        ent_req.wr    = match && !(act_q == ACT_RELEASE && mismatch);
        ent_req.ovf   = cur_ovf_q;
        ent_req.addr  = cur_at_q;
        ent_req.wdata = hit_upd;
      end
      S_SCAN_RD: begin
        bm_req.rd   = !scan_end;
        bm_req.addr = byte_q[BYTE_W-1:0];
      end
      S_SCAN_CHK: begin
        ent_req.wr         = !byte_full && emp_vld_q;
        ent_req.ovf        = emp_ovf_q;
        ent_req.addr       = emp_at_q;
        ent_req.wdata      = fill_ent;
        ent_req.wdata.slot = new_slot;
        ent_req.wdata.link = emp_link_q;
        bm_req.wr          = !byte_full && emp_vld_q;
        bm_req.addr        = byte_q[BYTE_W-1:0];
        bm_req.wdata       = set_byte;
      end
      S_OVF_RD: begin
        ent_req.rd   = (ovf_idx_q != LINK_W'(SLOT_COUNT));
        ent_req.ovf  = 1'b1;
        ent_req.addr = ovf_idx_q[SLOT_W-1:0];
      end
      S_OVF_CHK: begin
        ent_req.wr         = ovf_free;
        ent_req.ovf        = 1'b1;
        ent_req.addr       = ovf_idx_q[SLOT_W-1:0];
        ent_req.wdata      = fill_ent;
        ent_req.wdata.slot = res_slot_q;
      end
      S_LINK: begin
        ent_req.wr         = 1'b1;
        ent_req.ovf        = tail_ovf_q;
        ent_req.addr       = tail_at_q;
        ent_req.wdata      = tail_ent_q;
        ent_req.wdata.link = ovf_idx_q + LINK_W'(1);
        bm_req.wr          = 1'b1;
        bm_req.addr        = res_slot_q[SLOT_W-1:3];
        bm_req.wdata       = bm_byte_q;
      end
      S_BCLR_RD: begin
        bm_req.rd   = 1'b1;
        bm_req.addr = res_slot_q[SLOT_W-1:3];
      end
      S_BCLR_WR: begin
        bm_req.wr    = 1'b1;
        bm_req.addr  = res_slot_q[SLOT_W-1:3];
        bm_req.wdata = bm_rdata & ~(8'b1 << res_slot_q[2:0]);
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    clr_d        = clr_q;
    act_d        = act_q;
    hi_d         = hi_q;
    lo_d         = lo_q;
    fl_d         = fl_q;
    rslot_d      = rslot_q;
    cur_ovf_d    = cur_ovf_q;
    cur_at_d     = cur_at_q;
    emp_vld_d    = emp_vld_q;
    emp_ovf_d    = emp_ovf_q;
    emp_at_d     = emp_at_q;
    emp_link_d   = emp_link_q;
    tail_ovf_d   = tail_ovf_q;
    tail_at_d    = tail_at_q;
    tail_ent_d   = tail_ent_q;
    byte_d       = byte_q;
    bm_byte_d    = bm_byte_q;
    ovf_idx_d    = ovf_idx_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    res_view_d   = res_view_q;
    unique case (state_q)
      S_CLEAR: clr_d = clr_q + SLOT_W'(1);
      S_IDLE: begin
        if (req_fire) begin
          act_d        = req_i.action;
          hi_d         = req_i.object_id_high;
          lo_d         = req_i.object_id_low;
          fl_d         = req_i.request_flags;
          rslot_d      = req_i.release_slot;
          cur_ovf_d    = 1'b0;
          cur_at_d     = req_i.object_id_low[SLOT_W-1:0];
          emp_vld_d    = 1'b0;
          res_slot_d   = '0;
          res_status_d = ST_NOT_FOUND;
          res_view_d   = VIEW_NONE;
        end
      end
      S_FIND_CHK: begin
        if (match) begin
          priority if (act_q == ACT_ALLOC) begin
            res_slot_d   = ent.slot;
            res_status_d = ST_SHARED;
          end else if (mismatch) begin
            res_status_d = ST_MISMATCH;
          end else if (!last_ref) begin
            res_slot_d   = ent.slot;
            res_status_d = ST_DECR;
          end else begin
            res_slot_d   = ent.slot;
            res_status_d = ST_FREED;
            res_view_d   = VIEW_CLEAR;
          end
        end else begin
          if (!occupied && !emp_vld_q) begin
            emp_vld_d  = 1'b1;
            emp_ovf_d  = cur_ovf_q;
            emp_at_d   = cur_at_q;
            emp_link_d = ent.link;
          end
          tail_ovf_d = cur_ovf_q;
          tail_at_d  = cur_at_q;
          tail_ent_d = ent;
          cur_ovf_d  = 1'b1;
          cur_at_d   = SLOT_W'(ent.link - LINK_W'(1));
          byte_d     = first_byte;
        end
      end
      S_SCAN_RD: begin
        if (scan_end) res_status_d = ST_NO_SPACE;
      end
      S_SCAN_CHK: begin
        if (byte_full) begin
          byte_d = byte_q + (BYTE_W + 1)'(1);
        end else begin
          res_slot_d = new_slot;
          bm_byte_d  = set_byte;
          ovf_idx_d  = '0;
          if (emp_vld_q) begin
            res_status_d = ST_NEW;
            res_view_d   = VIEW_SET;
          end
        end
      end
      S_OVF_RD: begin
        if (ovf_idx_q == LINK_W'(SLOT_COUNT)) begin
          res_slot_d   = '0;
          res_status_d = ST_TABLE_FULL;
        end
      end
      S_OVF_CHK: begin
        if (ovf_free) begin
          res_status_d = ST_NEW;
          res_view_d   = VIEW_SET;
        end else begin
          ovf_idx_d = ovf_idx_q + LINK_W'(1);
        end
      end
      S_FIND_RD, S_LINK, S_BCLR_RD, S_BCLR_WR, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) out_vld_d = 1'b1;
    else if (rsp_fire) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      first_q   <= '0;
      last_q    <= '1;
      out_vld_q <= 1'b0;
      emp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      emp_vld_q <= emp_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_FIRST_SLOT) first_q <= SLOT_W'(cfg_i.data);
        if (cfg_i.index == CFG_LAST_SLOT) last_q <= SLOT_W'(cfg_i.data);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    hi_q         <= hi_d;
    lo_q         <= lo_d;
    fl_q         <= fl_d;
    rslot_q      <= rslot_d;
    cur_ovf_q    <= cur_ovf_d;
    cur_at_q     <= cur_at_d;
    emp_ovf_q    <= emp_ovf_d;
    emp_at_q     <= emp_at_d;
    emp_link_q   <= emp_link_d;
    tail_ovf_q   <= tail_ovf_d;
    tail_at_q    <= tail_at_d;
    tail_ent_q   <= tail_ent_d;
    byte_q       <= byte_d;
    bm_byte_q    <= bm_byte_d;
    ovf_idx_q    <= ovf_idx_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    res_view_q   <= res_view_d;
    if (out_load) begin
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
      out_view_q   <= res_view_q;
    end
  end

endmodule

// ----- rtl/rsa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the refcounted slot allocator, bound to the top level.
// Depends on rsa_pkg and refcounted_slot_allocator.
module rsa_checker import rsa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [SLOT_W-1:0] rsp_slot_i,
  input logic [2:0]        rsp_status_i,
  input logic [1:0]        rsp_view_i
);

  logic [1:0] pend_q, pend_d;
  logic       req_fire, rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (req_fire && !rsp_fire) pend_d = pend_q + 2'd1;
    else if (!req_fire && rsp_fire) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i
      && $stable({rsp_slot_i, rsp_status_i, rsp_view_i}))
    else $error("response item changed while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response item without an accepted request");

  a_no_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !req_ready_i)
    else $error("request accepted with two items outstanding");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NO_SPACE || rsp_status_i == ST_TABLE_FULL
      || rsp_status_i == ST_NOT_FOUND || rsp_status_i == ST_MISMATCH)
      |-> rsp_slot_i == '0 && rsp_view_i == VIEW_NONE)
    else $error("error response carries a slot or view update");

  a_view_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_view_i != VIEW_NONE
      |-> (rsp_view_i == VIEW_SET && rsp_status_i == ST_NEW)
       || (rsp_view_i == VIEW_CLEAR && rsp_status_i == ST_FREED))
    else $error("view update does not fit the status");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_slot_i   (rsp_o.slot_number),
  .rsp_status_i (rsp_o.status),
  .rsp_view_i   (rsp_o.view_update)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of refcounted_slot_allocator: directed table, shared-count run,
// allocation window settings and random traffic checked against a behavioral tracker.
// Depends on rsa_pkg, rsa_if and the RTL top level.
module testbench;
  import rsa_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned KEY_COUNT  = 48;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
    view_e             view;
  } answer_t;

  typedef struct {
    logic         act;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [31:0]  fl;
    logic [9:0]   rs;
    bit           typed;
    answer_t      ans;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rsa_cfg_if cfg_if ();
  rsa_req_if req_if ();
  rsa_rsp_if rsp_if ();

  refcounted_slot_allocator i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Tracked table state: index 0 is the home table, index 1 the overflow table.
  logic [63:0]         tab_hi   [2][SLOT_COUNT];
  logic [63:0]         tab_lo   [2][SLOT_COUNT];
  logic [31:0]         tab_fl   [2][SLOT_COUNT];
  logic [SLOT_W-1:0]   tab_slot [2][SLOT_COUNT];
  logic [REF_BITS-1:0] tab_refs [2][SLOT_COUNT];
  logic [LINK_W-1:0]   tab_link [2][SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_used;
  logic [CFG_W-1:0]    first_slot;
  logic [CFG_W-1:0]    last_slot;

  answer_t pending_answers[$];
  int unsigned fails;
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned idle_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;

  logic [63:0] key_hi[KEY_COUNT];
  logic [63:0] key_lo[KEY_COUNT];
  logic [31:0] key_fl[KEY_COUNT];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit lookup(input logic [63:0] hi, input logic [63:0] lo,
                                input logic [31:0] fl, output int t, output int at);
    logic [LINK_W-1:0] l;
    t  = 0;
    at = int'(lo[SLOT_W-1:0]);
    for (int s = 0; s <= SLOT_COUNT; s++) begin
      if ((tab_hi[t][at] | tab_lo[t][at]) != 0 && tab_hi[t][at] == hi &&
          tab_lo[t][at] == lo && tab_fl[t][at] == fl) return 1'b1;
      l = tab_link[t][at];
      if (l == 0 || l > SLOT_COUNT) return 1'b0;
      at = int'(l) - 1;
      t  = 1;
    end
    return 1'b0;
  endfunction

  function automatic void fill(input int t, input int at, input logic [63:0] hi,
                               input logic [63:0] lo, input logic [31:0] fl,
                               input logic [SLOT_W-1:0] slot);
    tab_hi[t][at]   = hi;
    tab_lo[t][at]   = lo;
    tab_fl[t][at]   = fl;
    tab_slot[t][at] = slot;
    tab_refs[t][at] = 1;
  endfunction

  function automatic bit place(input logic [63:0] hi, input logic [63:0] lo,
                               input logic [31:0] fl, input logic [SLOT_W-1:0] slot);
    int t;
    int at;
    logic [LINK_W-1:0] l;
    t  = 0;
    at = int'(lo[SLOT_W-1:0]);
    for (int s = 0; s <= SLOT_COUNT; s++) begin
      if ((tab_hi[t][at] | tab_lo[t][at]) == 0) begin
        fill(t, at, hi, lo, fl, slot);
        return 1'b1;
      end
      l = tab_link[t][at];
      if (l == 0 || l > SLOT_COUNT) break;
      at = int'(l) - 1;
      t  = 1;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if ((tab_hi[1][i] | tab_lo[1][i]) == 0 && tab_link[1][i] == 0) begin
        fill(1, i, hi, lo, fl, SLOT_W'(slot));
        tab_link[t][at] = LINK_W'(i + 1);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit free_slot(output logic [SLOT_W-1:0] slot);
    for (int b = first_slot / 8; b <= last_slot / 8 && b < BYTE_COUNT; b++) begin
      for (int k = 0; k < 8; k++) begin
        if (!slot_used[b * 8 + k]) begin
          slot = SLOT_W'(b * 8 + k);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic answer_t predict_answer(input logic act, input logic [63:0] hi,
                                             input logic [63:0] lo, input logic [31:0] fl,
                                             input logic [SLOT_W-1:0] rs);
    answer_t a;
    int t;
    int at;
    bit hit;
    logic [SLOT_W-1:0] s;
    a = '{slot: '0, status: ST_NOT_FOUND, view: VIEW_NONE};
    if ((hi | lo) == 0) return a;
    hit = lookup(hi, lo, fl, t, at);
    if (act == ACT_ALLOC) begin
      if (hit) begin
        if (tab_refs[t][at] < REF_MAX) tab_refs[t][at]++;
        a.slot   = tab_slot[t][at];
        a.status = ST_SHARED;
      end else if (!free_slot(s)) begin
        a.status = ST_NO_SPACE;
      end else if (!place(hi, lo, fl, s)) begin
        a.status = ST_TABLE_FULL;
      end else begin
        slot_used[s] = 1'b1;
        a = '{slot: s, status: ST_NEW, view: VIEW_SET};
      end
    end else if (hit) begin
      if (tab_slot[t][at] != rs) begin
        a.status = ST_MISMATCH;
      end else if (tab_refs[t][at] > 1) begin
        tab_refs[t][at]--;
        a.slot   = tab_slot[t][at];
        a.status = ST_DECR;
      end else begin
        a = '{slot: tab_slot[t][at], status: ST_FREED, view: VIEW_CLEAR};
        slot_used[tab_slot[t][at]] = 1'b0;
        tab_hi[t][at]   = '0;
        tab_lo[t][at]   = '0;
        tab_fl[t][at]   = '0;
        tab_slot[t][at] = '0;
        tab_refs[t][at] = '0;
      end
    end
    return a;
  endfunction

  task automatic send_item(input logic act, input logic [63:0] hi, input logic [63:0] lo,
                           input logic [31:0] fl, input logic [SLOT_W-1:0] rs,
                           input bit typed, input answer_t typed_ans);
    answer_t a;
    if ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.action         <= act;
    req_if.object_id_high <= hi;
    req_if.object_id_low  <= lo;
    req_if.request_flags  <= fl;
    req_if.release_slot   <= rs;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    a = predict_answer(act, hi, lo, fl, rs);
    pending_answers.push_back(typed ? typed_ans : a);
    req_count++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    if (idx == CFG_FIRST_SLOT) first_slot = data;
    else last_slot = data;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] lo_slot, input logic [CFG_W-1:0] hi_slot);
    drain();
    write_reg(CFG_FIRST_SLOT, lo_slot);
    write_reg(CFG_LAST_SLOT, hi_slot);
  endtask

  task automatic random_items(input int n);
    int k;
    int t;
    int at;
    int r;
    logic [SLOT_W-1:0] rs;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(KEY_COUNT - 1);
      r = $urandom_range(99);
      rs = SLOT_W'($urandom);
      if (lookup(key_hi[k], key_lo[k], key_fl[k], t, at)) rs = tab_slot[t][at];
      if (r < 55) begin
        send_item(ACT_ALLOC, key_hi[k], key_lo[k], key_fl[k], SLOT_W'($urandom), 0, '0);
      end else if (r < 88) begin
        send_item(ACT_RELEASE, key_hi[k], key_lo[k], key_fl[k], rs, 0, '0);
      end else if (r < 93) begin
        send_item(ACT_RELEASE, key_hi[k], key_lo[k], key_fl[k], rs ^ SLOT_W'($urandom_range(1, 1023)),
                  0, '0);
      end else if (r < 97) begin
        send_item(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                  SLOT_W'($urandom), 0, '0);
      end else begin
        send_item(1'($urandom), '0, '0, $urandom, SLOT_W'($urandom), 0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      rsp_count++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected item slot=%0d status=%0d view=%0d", $time,
                 rsp_if.slot_number, rsp_if.status, rsp_if.view_update);
        fails++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.slot_number !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_if.slot_number);
          fails++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
          fails++;
        end
        if (rsp_if.view_update !== want.view) begin
          $display("%0t: view expected %0d actual %0d", $time, want.view, rsp_if.view_update);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    logic [9:0] buckets[6];
    fails = 0;
    req_count = 0;
    rsp_count = 0;
    idle_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_ALLOC;
    req_if.object_id_high = '0;
    req_if.object_id_low = '0;
    req_if.request_flags = '0;
    req_if.release_slot = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FIRST_SLOT;
    cfg_if.data = '0;
    rsp_if.ready = 1'b1;
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tab_hi[t][i] = '0; tab_lo[t][i] = '0; tab_fl[t][i] = '0;
        tab_slot[t][i] = '0; tab_refs[t][i] = '0; tab_link[t][i] = '0;
      end
    end
    slot_used = '0;
    first_slot = 0;
    last_slot = 1023;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows = '{
      '{ACT_ALLOC,   '0,  '0,      '0, '0, 1, '{0, ST_NOT_FOUND, VIEW_NONE}},
      '{ACT_RELEASE, '0,  '0,      '1, '1, 1, '{0, ST_NOT_FOUND, VIEW_NONE}},
      '{ACT_ALLOC,   '1,  '1,      '1, '0, 1, '{0, ST_NEW, VIEW_SET}},
      '{ACT_ALLOC,   '1,  '1,      '1, '0, 0, '{0, ST_SHARED, VIEW_NONE}},
      '{ACT_ALLOC,   '0,  64'h1,   '0, '0, 0, '{1, ST_NEW, VIEW_SET}},
      '{ACT_ALLOC,   64'h5, 64'h3ff, '0, '0, 0, '{2, ST_NEW, VIEW_SET}},
      '{ACT_ALLOC,   64'h5, 64'h3ff, 32'h1, '0, 0, '{3, ST_NEW, VIEW_SET}},
      '{ACT_RELEASE, '1,  '1,      '1, 10'd5, 1, '{0, ST_MISMATCH, VIEW_NONE}},
      '{ACT_RELEASE, 64'h9, 64'h7, '0, '0, 1, '{0, ST_NOT_FOUND, VIEW_NONE}},
      '{ACT_RELEASE, '1,  '1,      '1, '0, 0, '{0, ST_DECR, VIEW_NONE}},
      '{ACT_RELEASE, '1,  '1,      '1, '0, 0, '{0, ST_FREED, VIEW_CLEAR}},
      '{ACT_RELEASE, 64'h5, 64'h3ff, '0, 10'd2, 0, '{2, ST_FREED, VIEW_CLEAR}},
      '{ACT_ALLOC,   '1,  '1,      '1, '0, 0, '{0, ST_NEW, VIEW_SET}},
      '{ACT_ALLOC,   64'h5, 64'h3ff, '0, '0, 0, '{2, ST_NEW, VIEW_SET}},
      '{ACT_RELEASE, '0,  64'h1,   '0, 10'd1, 0, '{1, ST_FREED, VIEW_CLEAR}},
      '{ACT_RELEASE, 64'h5, 64'h3ff, 32'h1, 10'd3, 0, '{3, ST_FREED, VIEW_CLEAR}},
      '{ACT_RELEASE, '1,  '1,      '1, '0, 0, '{0, ST_FREED, VIEW_CLEAR}},
      '{ACT_RELEASE, 64'h5, 64'h3ff, '0, 10'd2, 0, '{2, ST_FREED, VIEW_CLEAR}}
    };
    write_reg(CFG_FIRST_SLOT, 10'd0);
    write_reg(CFG_LAST_SLOT, 10'd1023);
    foreach (rows[i])
      send_item(rows[i].act, rows[i].hi, rows[i].lo, rows[i].fl, rows[i].rs,
                rows[i].typed, rows[i].ans);

    // Empty window: first byte above last byte.
    set_window(10'd1023, 10'd0);
    send_item(ACT_ALLOC, 64'h11, 64'h22, '0, '0, 1, '{0, ST_NO_SPACE, VIEW_NONE});
    // One-byte window: fill it, overflow it, then empty it.
    set_window(10'd8, 10'd15);
    for (int i = 0; i < 9; i++) send_item(ACT_ALLOC, 64'h40, 64'(i + 1), '0, '0, 0, '0);
    for (int i = 0; i < 8; i++) send_item(ACT_RELEASE, 64'h40, 64'(i + 1), '0, 10'(8 + i), 0, '0);

    // Share one entry a few times, then step it back down.
    set_window(10'd1023, 10'd1023);
    for (int i = 0; i < 4; i++)
      send_item(ACT_ALLOC, 64'h77, 64'h300, 32'hcafe, '0, 0, '0);
    send_item(ACT_RELEASE, 64'h77, 64'h300, 32'hcafe, 10'd1016, 0, '0);
    send_item(ACT_RELEASE, 64'h77, 64'h300, 32'hcafe, 10'd1016, 0, '0);

    buckets = '{10'h000, 10'h3ff, 10'h155, 10'h2aa, 10'h021, 10'h3e0};
    for (int i = 0; i < KEY_COUNT; i++) begin
      key_hi[i] = {$urandom, $urandom};
      key_lo[i] = {$urandom, $urandom};
      key_lo[i][9:0] = buckets[i % 6];
      key_fl[i] = $urandom;
      if (i % 8 == 7) begin
        key_hi[i] = key_hi[i - 1];
        key_lo[i] = key_lo[i - 1];
      end
      if ((key_hi[i] | key_lo[i]) == 0) key_hi[i] = 64'h1;
    end

    set_window(10'd0, 10'd1023);
    random_items(110);
    gap_pct = 60;
    random_items(110);
    set_window(10'($urandom_range(0, 511)), 10'($urandom_range(512, 1023)));
    gap_pct = 0;
    stall_pct = 60;
    random_items(110);
    drain();
    gap_pct = 16;
    stall_pct = 16;
    set_window(10'($urandom_range(0, 40)), 10'($urandom_range(0, 60)));
    random_items(110);
    set_window(10'd0, 10'd1023);
    stall_pct = 0;
    gap_pct = 0;
    random_items(30);

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d request items and %0d response items over several allocation windows,",
             req_count, rsp_count);
    $display("shared counts, chained buckets and all four idling mixes; %0d mismatches.",
             fails);
    if (fails == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rsa_pkg.sv
rtl/rsa_if.sv
rtl/rsa_tables.sv
rtl/refcounted_slot_allocator.sv
rtl/rsa_checker.sv
sim/testbench.sv
